// File: design/nbnsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbnsq_pkg
// Shared types and constants for the name-service query parser.
// ----------------------------------------------------------------------------
package nbnsq_pkg;

	localparam int unsigned NAME_CHARS = 15;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned LEN_W      = 4;
	localparam int unsigned IDX_W      = 4;

	localparam logic [POS_W-1:0] POS_LIMIT    = 6'd50;
	localparam logic [POS_W-1:0] MIN_LAST_POS = 6'd49;
	localparam logic [POS_W-1:0] POS_TID_HI   = 6'd0;
	localparam logic [POS_W-1:0] POS_TID_LO   = 6'd1;
	localparam logic [POS_W-1:0] POS_FLAGS    = 6'd2;
	localparam logic [POS_W-1:0] POS_QD_HI    = 6'd4;
	localparam logic [POS_W-1:0] POS_QD_LO    = 6'd5;
	localparam logic [POS_W-1:0] POS_NAME_LEN = 6'd12;
	localparam logic [POS_W-1:0] POS_NAME_LO  = 6'd13;
	localparam logic [POS_W-1:0] POS_NAME_HI  = 6'd44;
	localparam logic [POS_W-1:0] POS_NAME_PR  = 6'd14;
	localparam logic [POS_W-1:0] POS_TERM     = 6'd45;
	localparam logic [POS_W-1:0] POS_TYPE_HI  = 6'd46;
	localparam logic [POS_W-1:0] POS_TYPE_LO  = 6'd47;

	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] BYTE_ONE   = 8'h01;
	localparam logic [7:0] NAME_LEN_B = 8'h20;
	localparam logic [7:0] QTYPE_LO   = 8'h20;

	typedef struct packed {
		logic                            ok;
		logic [15:0]                     tid;
		logic [LEN_W-1:0]                len;
		logic [NAME_CHARS-1:0][7:0]      name;
	} job_t;

endpackage

// File: design/nbnsq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbnsq_front
// Byte parser: checks header and name, decodes nibble pairs, and posts one
// job per datagram at its final byte.
// ----------------------------------------------------------------------------
module nbnsq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                job_push,
	output nbnsq_pkg::job_t     job
);

	logic [nbnsq_pkg::POS_W-1:0]               pos_q;
	logic [15:0]                               tid_q;
	logic                                      reject_q;
	logic [3:0]                                held_q;
	logic [nbnsq_pkg::LEN_W-1:0]               trim_q;
	logic [nbnsq_pkg::NAME_CHARS-1:0][7:0]     name_q;

	logic       bad;
	logic       is_letter;
	logic [7:0] diff;
	logic [3:0] nib;
	logic [4:0] idx;
	logic [7:0] raw;
	logic       in_name;

	always_comb begin
		diff      = data_byte - nbnsq_pkg::CH_A;
		is_letter = (data_byte >= nbnsq_pkg::CH_A) && (data_byte <= nbnsq_pkg::CH_P);
		nib       = is_letter ? diff[3:0] : 4'd0;
		in_name   = (pos_q >= nbnsq_pkg::POS_NAME_LO) && (pos_q <= nbnsq_pkg::POS_NAME_HI);
		idx       = 5'((pos_q - nbnsq_pkg::POS_NAME_PR) >> 1);
		raw       = {held_q, nib};
		bad       = 1'b0;
		if (pos_q == nbnsq_pkg::POS_FLAGS) begin
			bad = data_byte[7] | (data_byte[6:3] != 4'd0);
		end else if (pos_q == nbnsq_pkg::POS_QD_HI) begin
			bad = data_byte != nbnsq_pkg::BYTE_ZERO;
		end else if (pos_q == nbnsq_pkg::POS_QD_LO) begin
			bad = data_byte != nbnsq_pkg::BYTE_ONE;
		end else if (pos_q == nbnsq_pkg::POS_NAME_LEN) begin
			bad = data_byte != nbnsq_pkg::NAME_LEN_B;
		end else if (in_name) begin
			bad = !is_letter;
		end else if (pos_q == nbnsq_pkg::POS_TERM || pos_q == nbnsq_pkg::POS_TYPE_HI) begin
			bad = data_byte != nbnsq_pkg::BYTE_ZERO;
		end else if (pos_q == nbnsq_pkg::POS_TYPE_LO) begin
			bad = data_byte != nbnsq_pkg::QTYPE_LO;
		end
	end

	assign job_push = take & last_byte;
	assign job.ok   = !reject_q && (pos_q >= nbnsq_pkg::MIN_LAST_POS) && (trim_q != '0);
	assign job.tid  = tid_q;
	assign job.len  = trim_q;
	assign job.name = name_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tid_q    <= '0;
			reject_q <= 1'b0;
			held_q   <= '0;
			trim_q   <= '0;
		end else if (take) begin
			if (last_byte) begin
				pos_q    <= '0;
				tid_q    <= '0;
				reject_q <= 1'b0;
				held_q   <= '0;
				trim_q   <= '0;
			end else if (pos_q != nbnsq_pkg::POS_LIMIT) begin
				pos_q <= pos_q + 1'b1;
				if (bad) begin
					reject_q <= 1'b1;
				end
				if (pos_q == nbnsq_pkg::POS_TID_HI) begin
					tid_q <= {data_byte, 8'h00};
				end else if (pos_q == nbnsq_pkg::POS_TID_LO) begin
					tid_q <= {tid_q[15:8], data_byte};
				end else if (in_name) begin
					if (pos_q[0]) begin
						held_q <= nib;
					end else if (idx < 5'(nbnsq_pkg::NAME_CHARS)) begin
						if (raw != nbnsq_pkg::CH_SPACE) begin
							trim_q <= idx[3:0] + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !last_byte && in_name && !pos_q[0]
				&& idx < 5'(nbnsq_pkg::NAME_CHARS)) begin
			name_q[idx[3:0]] <= raw;
		end
	end

endmodule

// File: design/nbnsq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbnsq_fifo
// Two-entry job queue between parser and emitter.
// ----------------------------------------------------------------------------
module nbnsq_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  nbnsq_pkg::job_t     wr_job,
	output logic                full,
	input  logic                rd,
	output logic                head_valid,
	output nbnsq_pkg::job_t     head
);

	nbnsq_pkg::job_t mem_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/nbnsq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbnsq_back
// Emitter: plays out name characters of the head job, then its status item.
// ----------------------------------------------------------------------------
module nbnsq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  nbnsq_pkg::job_t     head,
	output logic                head_pop,
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          out_char,
	output logic                is_status,
	output logic                accepted,
	output logic [15:0]         transaction_id,
	output logic [3:0]          name_length,
	output logic                last_result
);

	logic                          valid_q;
	logic [nbnsq_pkg::IDX_W-1:0]   idx_q;
	logic [7:0]                    char_q;
	logic                          status_q;
	logic                          acc_q;
	logic [15:0]                   tid_q;
	logic [3:0]                    len_q;
	logic                          load;
	logic                          do_char;

	assign load     = head_valid && (!valid_q || pop);
	assign do_char  = head.ok && (idx_q < head.len);
	assign head_pop = load && !do_char;

	assign empty          = !valid_q;
	assign out_char       = char_q;
	assign is_status      = status_q;
	assign accepted       = acc_q;
	assign transaction_id = tid_q;
	assign name_length    = len_q;
	assign last_result    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= do_char ? idx_q + 1'b1 : '0;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (do_char) begin
				char_q   <= head.name[idx_q];
				status_q <= 1'b0;
				acc_q    <= 1'b0;
				tid_q    <= '0;
				len_q    <= '0;
			end else begin
				char_q   <= '0;
				status_q <= 1'b1;
				acc_q    <= head.ok;
				tid_q    <= head.ok ? head.tid : 16'd0;
				len_q    <= head.ok ? head.len : 4'd0;
			end
		end
	end

endmodule

// File: design/netbios_name_query_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// netbios_name_query_parser_core
// Streaming name-service query parser: one byte per transaction in, name
// characters and a closing status transaction out.
// ----------------------------------------------------------------------------
// Channel   Handshake      Payload
// input     push / full    data_byte, last_byte
// result    pop / empty    out_char, is_status, accepted, transaction_id,
//                          name_length, last_result
//
// Bytes are taken one per cycle while full is low; full rises only while both
// job queue slots hold finished datagrams. Each datagram yields name_length + 1
// results, one per cycle while pop is high, limited by the emitter's single
// output register. Reset clears parser position, flags, queue and output state.
// ----------------------------------------------------------------------------
module netbios_name_query_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_char,
	output logic        is_status,
	output logic        accepted,
	output logic [15:0] transaction_id,
	output logic [3:0]  name_length,
	output logic        last_result
);

	nbnsq_pkg::job_t job;
	nbnsq_pkg::job_t head;
	logic            job_push;
	logic            head_valid;
	logic            head_pop;
	logic            take;

	assign take = push && !full;

	nbnsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.job_push  (job_push),
		.job       (job)
	);

	nbnsq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (job_push),
		.wr_job     (job),
		.full       (full),
		.rd         (head_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	nbnsq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.head_pop       (head_pop),
		.empty          (empty),
		.pop            (pop),
		.out_char       (out_char),
		.is_status      (is_status),
		.accepted       (accepted),
		.transaction_id (transaction_id),
		.name_length    (name_length),
		.last_result    (last_result)
	);

endmodule
